// ===== rtl/core/desa_pkg.sv =====
package desa_pkg;

    localparam int PTR_W     = 13;
    localparam int BASE_W    = 12;
    localparam int BYTES_W   = 16;
    localparam int CNT_W     = 8;
    localparam int BLK_W     = BYTES_W + 1;
    localparam int CFG_IDX_W = 2;

    localparam logic [PTR_W-1:0]  LIMIT_RESET = 13'h1000;
    localparam logic [BASE_W-1:0] BASE_RESET  = 12'h000;

    localparam logic [1:0] REQ_ALLOC = 2'd0;
    localparam logic [1:0] REQ_POP   = 2'd1;
    localparam logic [1:0] REQ_GET   = 2'd2;
    localparam logic [1:0] REQ_SET   = 2'd3;

    localparam logic END_BOTTOM = 1'b0;
    localparam logic END_TOP    = 1'b1;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_COLLIDE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_ARENA_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ARENA_LIMIT = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_EXEC,
        ST_POP_RD,
        ST_POP_UPD,
        ST_OUT
    } state_t;

endpackage

// ===== rtl/core/desa_blk_div.sv =====
module desa_blk_div #(
    parameter int GRANULE_BYTES = 16
) (
    input  logic                          aclk,
    input  logic [desa_pkg::BYTES_W-1:0]  bytes_in,
    output logic [desa_pkg::BLK_W-1:0]    blk_size
);

    localparam int     BW    = desa_pkg::BLK_W;
    localparam int     N_W   = desa_pkg::BYTES_W + 1;
    localparam int     G_W   = $clog2(GRANULE_BYTES);
    localparam int     SHIFT = N_W + G_W;
    localparam longint RECIP = ((longint'(1) << SHIFT) + GRANULE_BYTES - 1) / GRANULE_BYTES;
    localparam int     R_W   = $clog2(RECIP + 1);
    localparam int     P_W   = N_W + R_W;

    logic [N_W-1:0] num;
    logic [P_W-1:0] prod_reg;

    // round up to whole granules: (bytes + G - 1) / G by reciprocal multiply
    assign num = N_W'(bytes_in) + N_W'(GRANULE_BYTES - 1);

    always_ff @(posedge aclk) begin
        prod_reg <= P_W'(num) * P_W'(RECIP);
    end

    // add the header granule
    assign blk_size = BW'(prod_reg >> SHIFT) + BW'(1);

endmodule

// ===== rtl/core/double_ended_stack_allocator.sv =====
// Two stacks share an arena of granules: the bottom stack grows up from arena_base,
// the top stack grows down from arena_limit. Each item runs alone through a small
// sequencer around the block header memory (one synchronous RAM, read data registered):
// alloc runs the size rounding multiply, execute with header write, then the result;
// get and set run execute and result; pop runs execute, then per released block one
// header read and one pointer update, then the result. The header RAM is not cleared at
// reset, so there is no start-up pass; ARENA_GRANULES must be a power of two, headers
// being indexed by the low pointer bits. Configuration writes reload the matching
// pointer and are taken in any cycle; issue them only while the block is idle.
module double_ended_stack_allocator #(
    parameter int ARENA_GRANULES = 4096,
    parameter int GRANULE_BYTES  = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [desa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [desa_pkg::PTR_W-1:0]      cfg_wdata,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_req_type,
    input  logic                            s_which_end,
    input  logic [desa_pkg::BYTES_W-1:0]    s_alloc_bytes,
    input  logic [desa_pkg::CNT_W-1:0]      s_pop_count,
    input  logic [desa_pkg::PTR_W-1:0]      s_position,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [desa_pkg::PTR_W-1:0]      m_address,
    output logic                            m_status
);

    localparam int PW = desa_pkg::PTR_W;
    localparam int BW = desa_pkg::BLK_W;
    localparam int EW = desa_pkg::BLK_W + 1;
    localparam int IW = $clog2(ARENA_GRANULES);

    desa_pkg::state_t state_reg, state_next;

    logic [1:0]                     req_reg;
    logic                           end_reg;
    logic [desa_pkg::BYTES_W-1:0]   bytes_reg;
    logic [PW-1:0]                  pos_reg;
    logic [desa_pkg::CNT_W-1:0]     cnt_reg, cnt_next;

    logic [desa_pkg::BASE_W-1:0]    base_reg, base_next;
    logic [PW-1:0]                  limit_reg, limit_next;
    logic [PW-1:0]                  lo_reg, lo_next;
    logic [PW-1:0]                  up_reg, up_next;

    logic [PW-1:0]                  res_addr_reg, res_addr_next;
    logic                           res_status_reg, res_status_next;

    logic                           m_valid_reg, m_valid_next;
    logic [PW-1:0]                  m_address_reg, m_address_next;
    logic                           m_status_reg, m_status_next;

    logic [PW-1:0]                  hdr_mem [ARENA_GRANULES];
    logic [PW-1:0]                  hdr_rdata_reg;
    logic [IW-1:0]                  hdr_raddr;
    logic [IW-1:0]                  hdr_waddr;
    logic [PW-1:0]                  hdr_wdata;
    logic                           hdr_we;

    logic [BW-1:0]                  blk;
    logic [EW-1:0]                  sum_lo;
    logic [EW-1:0]                  diff_up;
    logic                           bot_ok;
    logic                           top_ok;
    logic                           alloc_ok;
    logic [PW-1:0]                  lo_base;
    logic [PW-1:0]                  room_up;
    logic [PW-1:0]                  room_lo;
    logic                           pop_live;
    logic                           out_free;
    logic                           s_xfer;
    logic                           cfg_xfer;

    desa_blk_div #(
        .GRANULE_BYTES (GRANULE_BYTES)
    ) u_blk_div (
        .aclk     (aclk),
        .bytes_in (bytes_reg),
        .blk_size (blk)
    );

    assign cfg_ready = 1'b1;
    assign cfg_xfer  = cfg_valid && cfg_ready;
    assign s_xfer    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    assign m_valid   = m_valid_reg;
    assign m_address = m_address_reg;
    assign m_status  = m_status_reg;

    assign lo_base = PW'(base_reg);
    assign sum_lo  = EW'(lo_reg) + EW'(blk);
    assign diff_up = EW'(up_reg) - EW'(blk);
    assign bot_ok  = sum_lo <= EW'(up_reg);
    assign top_ok  = (EW'(blk) <= EW'(up_reg)) && (diff_up >= EW'(lo_reg));
    assign alloc_ok = (end_reg == desa_pkg::END_TOP) ? top_ok : bot_ok;

    assign room_up  = limit_reg - up_reg;
    assign room_lo  = lo_reg - lo_base;
    assign pop_live = (cnt_reg != '0) &&
                      ((end_reg == desa_pkg::END_TOP) ? (up_reg < limit_reg)
                                                      : (lo_reg > lo_base));

    assign hdr_raddr = (end_reg == desa_pkg::END_TOP) ? IW'(up_reg) : IW'(lo_reg - PW'(1));

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            desa_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = (s_req_type == desa_pkg::REQ_ALLOC) ? desa_pkg::ST_DIV
                                                                     : desa_pkg::ST_EXEC;
                end
            end
            desa_pkg::ST_DIV: begin
                state_next = desa_pkg::ST_EXEC;
            end
            desa_pkg::ST_EXEC: begin
                state_next = (req_reg == desa_pkg::REQ_POP) ? desa_pkg::ST_POP_RD
                                                            : desa_pkg::ST_OUT;
            end
            desa_pkg::ST_POP_RD: begin
                state_next = pop_live ? desa_pkg::ST_POP_UPD : desa_pkg::ST_OUT;
            end
            desa_pkg::ST_POP_UPD: begin
                state_next = desa_pkg::ST_POP_RD;
            end
            desa_pkg::ST_OUT: begin
                if (out_free) begin
                    state_next = desa_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = desa_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready         = (state_reg == desa_pkg::ST_IDLE);
        cnt_next        = cnt_reg;
        base_next       = base_reg;
        limit_next      = limit_reg;
        lo_next         = lo_reg;
        up_next         = up_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_address_next  = m_address_reg;
        m_status_next   = m_status_reg;
        hdr_we          = 1'b0;
        hdr_waddr       = IW'(diff_up[PW-1:0]);
        hdr_wdata       = blk[PW-1:0];

        case (state_reg)
            desa_pkg::ST_IDLE: begin
                if (s_xfer) begin
                    cnt_next = s_pop_count;
                end
            end
            desa_pkg::ST_EXEC: begin
                res_addr_next   = '0;
                res_status_next = desa_pkg::STATUS_OK;
                case (req_reg)
                    desa_pkg::REQ_ALLOC: begin
                        if (!alloc_ok) begin
                            res_status_next = desa_pkg::STATUS_COLLIDE;
                        end else if (end_reg == desa_pkg::END_TOP) begin
                            up_next       = diff_up[PW-1:0];
                            hdr_we        = 1'b1;
                            hdr_waddr     = IW'(diff_up[PW-1:0]);
                            res_addr_next = diff_up[PW-1:0] + PW'(1);
                        end else begin
                            lo_next       = sum_lo[PW-1:0];
                            hdr_we        = 1'b1;
                            hdr_waddr     = IW'(sum_lo[PW-1:0] - PW'(1));
                            res_addr_next = lo_reg;
                        end
                    end
                    desa_pkg::REQ_GET: begin
                        res_addr_next = (end_reg == desa_pkg::END_TOP) ? up_reg : lo_reg;
                    end
                    desa_pkg::REQ_SET: begin
                        if (end_reg == desa_pkg::END_TOP) begin
                            up_next = pos_reg;
                        end else begin
                            lo_next = pos_reg;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            desa_pkg::ST_POP_UPD: begin
                cnt_next = cnt_reg - desa_pkg::CNT_W'(1);
                if (end_reg == desa_pkg::END_TOP) begin
                    up_next = (hdr_rdata_reg >= room_up) ? limit_reg : up_reg + hdr_rdata_reg;
                end else begin
                    lo_next = (hdr_rdata_reg >= room_lo) ? lo_base : lo_reg - hdr_rdata_reg;
                end
            end
            desa_pkg::ST_OUT: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_address_next = res_addr_reg;
                    m_status_next  = res_status_reg;
                end
            end
            default: begin
            end
        endcase

        // reload the arena bound and its pointer
        if (cfg_xfer) begin
            if (cfg_index == desa_pkg::CFG_ARENA_BASE) begin
                base_next = cfg_wdata[desa_pkg::BASE_W-1:0];
                lo_next   = PW'(cfg_wdata[desa_pkg::BASE_W-1:0]);
            end else if (cfg_index == desa_pkg::CFG_ARENA_LIMIT) begin
                limit_next = cfg_wdata;
                up_next    = cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= desa_pkg::ST_IDLE;
            cnt_reg     <= '0;
            base_reg    <= desa_pkg::BASE_RESET;
            limit_reg   <= desa_pkg::LIMIT_RESET;
            lo_reg      <= PW'(desa_pkg::BASE_RESET);
            up_reg      <= desa_pkg::LIMIT_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            base_reg    <= base_next;
            limit_reg   <= limit_next;
            lo_reg      <= lo_next;
            up_reg      <= up_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            req_reg   <= s_req_type;
            end_reg   <= s_which_end;
            bytes_reg <= s_alloc_bytes;
            pos_reg   <= s_position;
        end
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        m_address_reg  <= m_address_next;
        m_status_reg   <= m_status_next;
    end

    always_ff @(posedge aclk) begin
        if (hdr_we) begin
            hdr_mem[hdr_waddr] <= hdr_wdata;
        end
        hdr_rdata_reg <= hdr_mem[hdr_raddr];
    end

    a_hdr_write_on_alloc: assert property (@(posedge aclk) disable iff (!aresetn)
        hdr_we |-> (state_reg == desa_pkg::ST_EXEC && req_reg == desa_pkg::REQ_ALLOC))
        else $error("header write outside alloc execute");

    a_refused_keeps_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == desa_pkg::ST_EXEC && req_reg == desa_pkg::REQ_ALLOC && !alloc_ok
         && !cfg_valid) |=> ($stable(lo_reg) && $stable(up_reg)))
        else $error("refused alloc moved a pointer");

    a_pop_top_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == desa_pkg::ST_POP_UPD && end_reg == desa_pkg::END_TOP && !cfg_valid)
        |=> (up_reg <= limit_reg))
        else $error("top pop passed arena limit");

    a_pop_bottom_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == desa_pkg::ST_POP_UPD && end_reg == desa_pkg::END_BOTTOM && !cfg_valid)
        |=> (lo_reg >= lo_base))
        else $error("bottom pop passed arena base");

    a_result_presented: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == desa_pkg::ST_OUT && out_free) |=> m_valid_reg)
        else $error("result lost on leaving output state");

endmodule

// ===== sim/double_ended_stack_allocator_test.sv =====
`timescale 1ns / 1ps

localparam int HEAP_GRANULES = 4096;
localparam int GRANULE_SIZE  = 16;
localparam int PTR_W         = desa_pkg::PTR_W;
localparam int BASE_W        = desa_pkg::BASE_W;
localparam int BYTES_W       = desa_pkg::BYTES_W;
localparam int CNT_W         = desa_pkg::CNT_W;
localparam int CFG_IDX_W     = desa_pkg::CFG_IDX_W;

typedef struct {
    logic [1:0]         req_type;
    logic               which_end;
    logic [BYTES_W-1:0] alloc_bytes;
    logic [CNT_W-1:0]   pop_count;
    logic [PTR_W-1:0]   position;
} alloc_request_t;

typedef struct {
    logic [PTR_W-1:0] address;
    logic             status;
} alloc_result_t;

class alloc_scoreboard;
    int unsigned      base_gran;
    int unsigned      limit_gran;
    int unsigned      lower_ptr;
    int unsigned      upper_ptr;
    logic [PTR_W-1:0] header_size [HEAP_GRANULES];
    bit               header_valid [HEAP_GRANULES];
    alloc_result_t    expected_q[$];
    int               mismatches;

    function new();
        base_gran  = 32'(desa_pkg::BASE_RESET);
        limit_gran = 32'(desa_pkg::LIMIT_RESET);
        lower_ptr  = base_gran;
        upper_ptr  = limit_gran;
        mismatches = 0;
        foreach (header_valid[i]) header_valid[i] = 1'b0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [PTR_W-1:0] value);
        if (idx == desa_pkg::CFG_ARENA_BASE) begin
            base_gran = 32'(value[BASE_W-1:0]);
            lower_ptr = base_gran;
        end else if (idx == desa_pkg::CFG_ARENA_LIMIT) begin
            limit_gran = 32'(value);
            upper_ptr  = limit_gran;
        end
    endfunction

    function void store_header(int unsigned addr, int unsigned blk);
        header_size[addr % HEAP_GRANULES]  = PTR_W'(blk);
        header_valid[addr % HEAP_GRANULES] = 1'b1;
    endfunction

    // Largest pop count whose header walk reads only written entries.
    function int safe_pop_steps(logic top);
        int unsigned ptr;
        int unsigned h;
        int          steps;
        ptr = top ? upper_ptr : lower_ptr;
        if (top) begin
            if (ptr == limit_gran) return 255;
            for (steps = 0; steps < 255; steps++) begin
                if (ptr >= limit_gran) return 255;
                if (!header_valid[ptr % HEAP_GRANULES]) return steps;
                h = 32'(header_size[ptr % HEAP_GRANULES]);
                if (h >= limit_gran - ptr) ptr = limit_gran;
                else ptr += h;
            end
        end else begin
            if (ptr == base_gran) return 255;
            for (steps = 0; steps < 255; steps++) begin
                if (ptr <= base_gran) return 255;
                if (!header_valid[(ptr - 1) % HEAP_GRANULES]) return steps;
                h = 32'(header_size[(ptr - 1) % HEAP_GRANULES]);
                if (h >= ptr - base_gran) ptr = base_gran;
                else ptr -= h;
            end
        end
        return 255;
    endfunction

    function void note_request(alloc_request_t r);
        alloc_result_t res;
        int unsigned   blk;
        int unsigned   h;
        int            k;
        res.address = '0;
        res.status  = desa_pkg::STATUS_OK;
        case (r.req_type)
            desa_pkg::REQ_ALLOC: begin
                blk = (32'(r.alloc_bytes) + GRANULE_SIZE - 1) / GRANULE_SIZE + 1;
                if (r.which_end == desa_pkg::END_TOP) begin
                    if (blk <= upper_ptr && upper_ptr - blk >= lower_ptr) begin
                        upper_ptr -= blk;
                        store_header(upper_ptr, blk);
                        res.address = PTR_W'(upper_ptr + 1);
                    end else begin
                        res.status = desa_pkg::STATUS_COLLIDE;
                    end
                end else begin
                    if (lower_ptr + blk <= upper_ptr) begin
                        res.address = PTR_W'(lower_ptr);
                        lower_ptr += blk;
                        store_header(lower_ptr - 1, blk);
                    end else begin
                        res.status = desa_pkg::STATUS_COLLIDE;
                    end
                end
            end
            desa_pkg::REQ_POP: begin
                if (r.which_end == desa_pkg::END_TOP) begin
                    if (upper_ptr != limit_gran) begin
                        for (k = 0; k < r.pop_count; k++) begin
                            if (upper_ptr < limit_gran) begin
                                h = 32'(header_size[upper_ptr % HEAP_GRANULES]);
                                if (h >= limit_gran - upper_ptr) upper_ptr = limit_gran;
                                else upper_ptr += h;
                            end
                        end
                    end
                end else begin
                    if (lower_ptr != base_gran) begin
                        for (k = 0; k < r.pop_count; k++) begin
                            if (lower_ptr > base_gran) begin
                                h = 32'(header_size[(lower_ptr - 1) % HEAP_GRANULES]);
                                if (h >= lower_ptr - base_gran) lower_ptr = base_gran;
                                else lower_ptr -= h;
                            end
                        end
                    end
                end
            end
            desa_pkg::REQ_GET: begin
                res.address = PTR_W'((r.which_end == desa_pkg::END_TOP) ? upper_ptr
                                                                        : lower_ptr);
            end
            default: begin
                if (r.which_end == desa_pkg::END_TOP) upper_ptr = 32'(r.position);
                else lower_ptr = 32'(r.position);
            end
        endcase
        expected_q.push_back(res);
    endfunction

    function void check_result(logic [PTR_W-1:0] address, logic status);
        alloc_result_t exp_res;
        if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: address %0d status %0d", address, status);
            return;
        end
        exp_res = expected_q.pop_front();
        if (exp_res.address !== address || exp_res.status !== status) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected address %0d status %0d, got address %0d status %0d",
                         exp_res.address, exp_res.status, address, status);
        end
    endfunction
endclass

module double_ended_stack_allocator_test;

    localparam int WATCHDOG_CYCLES = 4000;
    localparam int PHASE_ITEMS     = 130;
    localparam int PHASES          = 10;
    localparam int HOLD_AFTER      = 400;
    localparam int HOLD_CYCLES     = 400;

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [PTR_W-1:0]     cfg_wdata     = '0;
    logic                 s_valid       = 1'b0;
    logic                 s_ready;
    logic [1:0]           s_req_type    = desa_pkg::REQ_GET;
    logic                 s_which_end   = desa_pkg::END_BOTTOM;
    logic [BYTES_W-1:0]   s_alloc_bytes = '0;
    logic [CNT_W-1:0]     s_pop_count   = '0;
    logic [PTR_W-1:0]     s_position    = '0;
    logic                 m_valid;
    logic                 m_ready       = 1'b0;
    logic [PTR_W-1:0]     m_address;
    logic                 m_status;

    alloc_scoreboard heap_model;
    int              idle_pct     = 0;
    int              results_seen = 0;
    int              quiet_cycles = 0;

    double_ended_stack_allocator #(
        .ARENA_GRANULES(HEAP_GRANULES),
        .GRANULE_BYTES (GRANULE_SIZE)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_which_end  (s_which_end),
        .s_alloc_bytes(s_alloc_bytes),
        .s_pop_count  (s_pop_count),
        .s_position   (s_position),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_address    (m_address),
        .m_status     (m_status)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            heap_model.check_result(m_address, m_status);
            results_seen++;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_CYCLES);
        $display("Regression FAIL");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off to back up the input.
    initial begin
        int burst;
        bit held_off;
        held_off = 1'b0;
        wait (aresetn);
        forever begin
            burst = int'($urandom_range(16, 1));
            if (!held_off && results_seen >= HOLD_AFTER) begin
                held_off = 1'b1;
                repeat (HOLD_CYCLES) begin
                    @(negedge aclk);
                    m_ready <= 1'b0;
                end
            end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
                repeat (burst) begin
                    @(negedge aclk);
                    m_ready <= 1'b0;
                end
            end else begin
                repeat (burst) begin
                    @(negedge aclk);
                    m_ready <= 1'b1;
                end
            end
        end
    end

    task automatic send_request(input alloc_request_t r);
        @(negedge aclk);
        s_valid       <= 1'b1;
        s_req_type    <= r.req_type;
        s_which_end   <= r.which_end;
        s_alloc_bytes <= r.alloc_bytes;
        s_pop_count   <= r.pop_count;
        s_position    <= r.position;
        do @(posedge aclk); while (!s_ready);
        heap_model.note_request(r);
    endtask

    task automatic sender_pause(input int cycles);
        repeat (cycles) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
    endtask

    task automatic issue(input logic [1:0] req, input logic end_sel,
                         input int unsigned bytes, input int unsigned count,
                         input int unsigned pos);
        alloc_request_t r;
        r.req_type    = req;
        r.which_end   = end_sel;
        r.alloc_bytes = BYTES_W'(bytes);
        r.pop_count   = CNT_W'(count);
        r.position    = PTR_W'(pos);
        send_request(r);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [PTR_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        do @(posedge aclk); while (!cfg_ready);
        heap_model.write_register(idx, value);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        sender_pause(1);
        while (heap_model.expected_q.size() != 0) @(posedge aclk);
    endtask

    task automatic set_arena(input int unsigned base_val, input int unsigned limit_val);
        settle();
        write_register(desa_pkg::CFG_ARENA_BASE, PTR_W'(base_val));
        write_register(desa_pkg::CFG_ARENA_LIMIT, PTR_W'(limit_val));
    endtask

    function automatic alloc_request_t random_request();
        alloc_request_t r;
        int             pick;
        int             steps;
        r.which_end   = 1'($urandom_range(1));
        r.alloc_bytes = BYTES_W'($urandom);
        r.pop_count   = CNT_W'($urandom);
        r.position    = PTR_W'($urandom_range(4096));
        pick = int'($urandom_range(99));
        if (pick < 45) begin
            r.req_type = desa_pkg::REQ_ALLOC;
            pick = int'($urandom_range(99));
            if (pick < 60)      r.alloc_bytes = BYTES_W'($urandom_range(64));
            else if (pick < 85) r.alloc_bytes = BYTES_W'($urandom_range(1024));
            else if (pick < 95) r.alloc_bytes = BYTES_W'($urandom_range(8192));
            else                r.alloc_bytes = BYTES_W'($urandom_range(65535));
        end else if (pick < 75) begin
            r.req_type = desa_pkg::REQ_POP;
            pick = int'($urandom_range(99));
            if (pick < 70)      r.pop_count = CNT_W'($urandom_range(4, 1));
            else if (pick < 80) r.pop_count = '0;
            else                r.pop_count = CNT_W'($urandom_range(255));
            steps = heap_model.safe_pop_steps(r.which_end);
            if (r.pop_count > steps) r.pop_count = CNT_W'(steps);
        end else if (pick < 88) begin
            r.req_type = desa_pkg::REQ_GET;
        end else begin
            r.req_type = desa_pkg::REQ_SET;
            if ($urandom_range(99) < 60)
                r.position = PTR_W'((r.which_end == desa_pkg::END_TOP) ? heap_model.limit_gran
                                                                       : heap_model.base_gran);
        end
        return r;
    endfunction

    initial begin
        int          phase;
        int unsigned base_val;
        int unsigned limit_val;
        heap_model = new();
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        issue(desa_pkg::REQ_GET,   desa_pkg::END_BOTTOM, 0, 0, 0);
        issue(desa_pkg::REQ_GET,   desa_pkg::END_TOP,    0, 0, 0);
        issue(desa_pkg::REQ_ALLOC, desa_pkg::END_BOTTOM, 0, 0, 0);
        issue(desa_pkg::REQ_ALLOC, desa_pkg::END_BOTTOM, 65535, 0, 0);
        issue(desa_pkg::REQ_ALLOC, desa_pkg::END_BOTTOM, 1, 0, 0);
        issue(desa_pkg::REQ_ALLOC, desa_pkg::END_TOP,    16, 0, 0);
        issue(desa_pkg::REQ_ALLOC, desa_pkg::END_TOP,    17, 0, 0);
        issue(desa_pkg::REQ_ALLOC, desa_pkg::END_TOP,    65535, 0, 0);
        issue(desa_pkg::REQ_POP,   desa_pkg::END_TOP,    0, 1, 0);
        issue(desa_pkg::REQ_POP,   desa_pkg::END_TOP,    0, 255, 0);
        issue(desa_pkg::REQ_POP,   desa_pkg::END_TOP,    0, 7, 0);
        issue(desa_pkg::REQ_POP,   desa_pkg::END_BOTTOM, 0, 255, 0);
        issue(desa_pkg::REQ_POP,   desa_pkg::END_BOTTOM, 0, 0, 0);
        issue(desa_pkg::REQ_SET,   desa_pkg::END_BOTTOM, 0, 0, 4096);
        issue(desa_pkg::REQ_SET,   desa_pkg::END_TOP,    0, 0, 0);
        issue(desa_pkg::REQ_ALLOC, desa_pkg::END_BOTTOM, 0, 0, 0);
        issue(desa_pkg::REQ_ALLOC, desa_pkg::END_TOP,    0, 0, 0);
        issue(desa_pkg::REQ_GET,   desa_pkg::END_BOTTOM, 0, 0, 0);
        issue(desa_pkg::REQ_SET,   desa_pkg::END_TOP,    0, 0, 4095);
        issue(desa_pkg::REQ_GET,   desa_pkg::END_TOP,    0, 0, 0);

        set_arena(4095, 4096);
        issue(desa_pkg::REQ_ALLOC, desa_pkg::END_BOTTOM, 0, 0, 0);
        issue(desa_pkg::REQ_ALLOC, desa_pkg::END_TOP,    0, 0, 0);
        issue(desa_pkg::REQ_POP,   desa_pkg::END_BOTTOM, 0, 1, 0);
        issue(desa_pkg::REQ_SET,   desa_pkg::END_BOTTOM, 0, 0, 100);
        issue(desa_pkg::REQ_POP,   desa_pkg::END_BOTTOM, 0, 3, 0);

        set_arena(3000, 1000);
        issue(desa_pkg::REQ_ALLOC, desa_pkg::END_BOTTOM, 0, 0, 0);
        issue(desa_pkg::REQ_ALLOC, desa_pkg::END_TOP,    0, 0, 0);
        issue(desa_pkg::REQ_SET,   desa_pkg::END_TOP,    0, 0, 2000);
        issue(desa_pkg::REQ_POP,   desa_pkg::END_TOP,    0, 1, 0);

        set_arena(0, 1);
        issue(desa_pkg::REQ_ALLOC, desa_pkg::END_BOTTOM, 0, 0, 0);
        issue(desa_pkg::REQ_ALLOC, desa_pkg::END_TOP,    0, 0, 0);

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin
                    base_val  = 0;
                    limit_val = 4096;
                end
                1: begin
                    base_val  = 0;
                    limit_val = 48;
                end
                2: begin
                    base_val  = 2048;
                    limit_val = 2112;
                end
                default: begin
                    base_val  = $urandom_range(4095);
                    limit_val = base_val + $urandom_range(600, 16);
                    if (limit_val > 4096) limit_val = 4096;
                end
            endcase
            set_arena(base_val, limit_val);
            if (phase == PHASES - 1 || phase == 4) idle_pct = 0;
            else idle_pct = int'($urandom_range(50, 10));
            repeat (PHASE_ITEMS) begin
                if (idle_pct != 0 && $urandom_range(99) < idle_pct)
                    sender_pause(int'($urandom_range(16, 1)));
                send_request(random_request());
            end
        end

        settle();
        repeat (20) @(posedge aclk);
        if (heap_model.mismatches == 0 && heap_model.expected_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== double_ended_stack_allocator.f =====
rtl/core/desa_pkg.sv
rtl/core/desa_blk_div.sv
rtl/core/double_ended_stack_allocator.sv
sim/double_ended_stack_allocator_test.sv
